// ----- design/dmarb_pkg.sv -----
// ----------------------------------------------------------------------------
// dmarb_pkg
// Shared types and constants of the DMA register block: decoded operation
// codes, queue entry and result layouts, register offsets and reset values.
// ----------------------------------------------------------------------------
package dmarb_pkg;

    // channel that owns registers and can start transfers
    localparam int unsigned LIVE_CHANNEL  = 4;
    localparam logic [2:0]  LIVE_SLOT     = 3'(LIVE_CHANNEL);
    localparam int unsigned LIVE_EN_BIT   = LIVE_CHANNEL * 4 + 3;
    localparam int unsigned LIVE_MASK_BIT = 16 + LIVE_CHANNEL;
    localparam int unsigned LIVE_FLAG_BIT = 24 + LIVE_CHANNEL;

    // request kinds
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_LINE  = 2'd2;

    // register window
    localparam logic [6:0] OFS_DPCR = 7'h70;
    localparam logic [6:0] OFS_DICR = 7'h74;
    localparam logic [1:0] REG_MADR = 2'd0;
    localparam logic [1:0] REG_BCR  = 2'd1;
    localparam logic [1:0] REG_CHCR = 2'd2;

    localparam logic [31:0] DPCR_RESET    = 32'h0765_4321;
    localparam logic [31:0] DICR_WR_MASK  = 32'h00ff_807f;
    localparam logic [31:0] DICR_FLAGS    = 32'h7f00_0000;
    localparam logic [23:0] MADR_MASK     = 24'hff_fffc;
    localparam logic [1:0]  CHCR_MODE_SLICE = 2'b01;

    // queue between decode and execute
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_RD_DPCR,
        OP_RD_DICR,
        OP_RD_MADR,
        OP_RD_BCR,
        OP_RD_CHCR,
        OP_WR_DPCR,
        OP_WR_DICR,
        OP_WR_MADR,
        OP_WR_BCR,
        OP_WR_CHCR,
        OP_REQ_SET,
        OP_REQ_CLR
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] data;
    } t_op_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        xfer_valid;
        logic        xfer_to_device;
        logic [23:0] xfer_address;
        logic [15:0] xfer_block_words;
        logic [15:0] xfer_block_count;
        logic        irq_master;
    } t_result;

    // master flag: bus error, or enabled and any masked flag raised
    function automatic logic [31:0] dicr_recompute(input logic [31:0] dicr);
        logic [31:0] d;
        d     = dicr & 32'h7fff_ffff;
        d[31] = d[15] | (d[23] & (|(d[30:24] & d[22:16])));
        return d;
    endfunction

endpackage

// ----- design/dmarb_if.sv -----
// ----------------------------------------------------------------------------
// dmarb_if
// Request and response channels of the DMA register block, valid/ready.
// ----------------------------------------------------------------------------
interface dmarb_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [6:0]  reg_offset;
    logic [31:0] write_data;
    logic [2:0]  request_channel;
    logic        request_level;

    modport source (
        output valid, req_type, reg_offset, write_data, request_channel,
               request_level,
        input  ready
    );
    modport sink (
        input  valid, req_type, reg_offset, write_data, request_channel,
               request_level,
        output ready
    );
endinterface

interface dmarb_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        xfer_valid;
    logic        xfer_to_device;
    logic [23:0] xfer_address;
    logic [15:0] xfer_block_words;
    logic [15:0] xfer_block_count;
    logic        irq_master;

    modport source (
        output valid, read_data, xfer_valid, xfer_to_device, xfer_address,
               xfer_block_words, xfer_block_count, irq_master,
        input  ready
    );
    modport sink (
        input  valid, read_data, xfer_valid, xfer_to_device, xfer_address,
               xfer_block_words, xfer_block_count, irq_master,
        output ready
    );
endinterface

// ----- design/dmarb_front.sv -----
// ----------------------------------------------------------------------------
// dmarb_front
// Accepts bus transactions and request line changes and decodes them into
// register operations for the execute stage.
// ----------------------------------------------------------------------------
module dmarb_front
    import dmarb_pkg::*;
(
    dmarb_req_if.sink i_req,
    input  logic      i_full,
    output logic      o_push,
    output t_op_item  o_item
);

    logic [2:0] slot;
    logic [1:0] idx;

    assign slot        = i_req.reg_offset[6:4];
    assign idx         = i_req.reg_offset[3:2];
    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    always_comb begin
        o_item.data = i_req.write_data;
        o_item.op   = OP_NONE;
        unique case (i_req.req_type)
            REQ_READ: begin
                if (i_req.reg_offset == OFS_DPCR) begin
                    o_item.op = OP_RD_DPCR;
                end else if (i_req.reg_offset == OFS_DICR) begin
                    o_item.op = OP_RD_DICR;
                end else if (slot == LIVE_SLOT) begin
                    unique case (idx)
                        REG_MADR: o_item.op = OP_RD_MADR;
                        REG_BCR:  o_item.op = OP_RD_BCR;
                        REG_CHCR: o_item.op = OP_RD_CHCR;
                        default:  o_item.op = OP_NONE;
                    endcase
                end
            end
            REQ_WRITE: begin
                if (i_req.reg_offset == OFS_DPCR) begin
                    o_item.op = OP_WR_DPCR;
                end else if (i_req.reg_offset == OFS_DICR) begin
                    o_item.op = OP_WR_DICR;
                end else if (slot == LIVE_SLOT) begin
                    unique case (idx)
                        REG_MADR: o_item.op = OP_WR_MADR;
                        REG_BCR:  o_item.op = OP_WR_BCR;
                        REG_CHCR: o_item.op = OP_WR_CHCR;
                        default:  o_item.op = OP_NONE;
                    endcase
                end
            end
            REQ_LINE: begin
                // only the live channel's line can start anything
                if (i_req.request_channel == LIVE_SLOT) begin
                    o_item.op = i_req.request_level ? OP_REQ_SET : OP_REQ_CLR;
                end
            end
            default: o_item.op = OP_NONE;
        endcase
    end

endmodule

// ----- design/dmarb_queue.sv -----
// ----------------------------------------------------------------------------
// dmarb_queue
// Short FIFO of decoded operations between the front and the execute stage.
// ----------------------------------------------------------------------------
module dmarb_queue
    import dmarb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_op_item i_item,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_empty,
    output t_op_item o_head
);

    t_op_item          r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_entry[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ----- design/dmarb_back.sv -----
// ----------------------------------------------------------------------------
// dmarb_back
// Execute stage: holds the DMA registers, applies one decoded operation per
// cycle unless a result waits, attempts slice starts and registers the result.
// ----------------------------------------------------------------------------
module dmarb_back
    import dmarb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_op_item   i_head,
    output logic       o_pop,
    dmarb_rsp_if.source o_rsp
);

    logic [31:0] r_dpcr, n_dpcr;
    logic [31:0] r_dicr, n_dicr;
    logic [23:0] r_madr, n_madr;
    logic [31:0] r_bcr,  n_bcr;
    logic [31:0] r_chcr, n_chcr;
    logic        r_req,  n_req;
    logic        r_out_valid;
    t_result     r_out, n_out;
    logic        start;

    assign o_pop = !i_empty && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_dpcr = r_dpcr;
        n_dicr = r_dicr;
        n_madr = r_madr;
        n_bcr  = r_bcr;
        n_chcr = r_chcr;
        n_req  = r_req;
        n_out  = '0;
        start  = 1'b0;
        case (i_head.op)
            OP_RD_DPCR: n_out.read_data = r_dpcr;
            OP_RD_DICR: n_out.read_data = r_dicr;
            OP_RD_MADR: n_out.read_data = {8'b0, r_madr};
            OP_RD_BCR:  n_out.read_data = r_bcr;
            OP_RD_CHCR: n_out.read_data = r_chcr;
            OP_WR_DPCR: n_dpcr = i_head.data;
            OP_WR_DICR: begin
                // flags whose new mask bit is set are cleared
                n_dicr = dicr_recompute((i_head.data & DICR_WR_MASK)
                    | (r_dicr & DICR_FLAGS & ~{1'b0, i_head.data[22:16], 24'b0}));
            end
            OP_WR_MADR: n_madr = i_head.data[23:0] & MADR_MASK;
            OP_WR_BCR:  n_bcr  = i_head.data;
            OP_WR_CHCR: begin
                n_chcr = i_head.data;
                start  = 1'b1;
            end
            OP_REQ_SET: begin
                n_req = 1'b1;
                start = 1'b1;
            end
            OP_REQ_CLR: n_req = 1'b0;
            default: ;
        endcase

        if (start && r_dpcr[LIVE_EN_BIT] && n_chcr[24] && n_req) begin
            n_chcr[28] = 1'b0;
            if (n_chcr[10:9] == CHCR_MODE_SLICE && !n_chcr[1]) begin
                n_out.xfer_valid       = 1'b1;
                n_out.xfer_to_device   = n_chcr[0];
                n_out.xfer_address     = r_madr;
                n_out.xfer_block_words = r_bcr[15:0];
                n_out.xfer_block_count = r_bcr[31:16];
                n_dicr[LIVE_FLAG_BIT]  = r_dicr[LIVE_FLAG_BIT] | r_dicr[LIVE_MASK_BIT];
                n_dicr                 = dicr_recompute(n_dicr);
            end
        end
        n_out.irq_master = n_dicr[31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpcr      <= DPCR_RESET;
            r_dicr      <= '0;
            r_madr      <= '0;
            r_bcr       <= '0;
            r_chcr      <= '0;
            r_req       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_dpcr <= n_dpcr;
                r_dicr <= n_dicr;
                r_madr <= n_madr;
                r_bcr  <= n_bcr;
                r_chcr <= n_chcr;
                r_req  <= n_req;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.read_data        = r_out.read_data;
    assign o_rsp.xfer_valid       = r_out.xfer_valid;
    assign o_rsp.xfer_to_device   = r_out.xfer_to_device;
    assign o_rsp.xfer_address     = r_out.xfer_address;
    assign o_rsp.xfer_block_words = r_out.xfer_block_words;
    assign o_rsp.xfer_block_count = r_out.xfer_block_count;
    assign o_rsp.irq_master       = r_out.irq_master;

`ifndef ASSERT_OFF
    a_irq_tracks_dicr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.irq_master == r_dicr[31]))
        else $error("result master flag differs from DICR");
    a_xfer_clears_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.xfer_valid) |-> !r_chcr[28])
        else $error("transfer issued without clearing start bit");
    a_xfer_not_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.xfer_valid) |-> (r_out.read_data == '0))
        else $error("transfer and read data in one result");
    a_master_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dicr[31] == (r_dicr[15] | (r_dicr[23] & (|(r_dicr[30:24] & r_dicr[22:16])))))
        else $error("DICR master flag inconsistent");
`endif

endmodule

// ----- design/dma_register_block_with_slice_trigger.sv -----
// a transaction accepted on i_req enters the queue; dmarb_back registers its result on pop
// throughput: one transaction per cycle while results are taken on the response side
// a two-entry queue lets requests be taken while a finished result waits on the response side
// reset: synchronous active-low i_rst_n; DPCR to 0x07654321, other registers, the request
// line and the result valid flag cleared, the queue emptied; no clearing pass
// ----------------------------------------------------------------------------
// dma_register_block_with_slice_trigger
// DMA controller register block with one live channel: decodes bus reads,
// writes and request line changes and issues slice-mode transfer descriptors.
// ----------------------------------------------------------------------------
module dma_register_block_with_slice_trigger
    import dmarb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    dmarb_req_if.sink   i_req,
    dmarb_rsp_if.source o_rsp
);

    logic     push;
    logic     pop;
    logic     full;
    logic     empty;
    t_op_item push_item;
    t_op_item head_item;

    dmarb_front u_front (
        .i_req  (i_req),
        .i_full (full),
        .o_push (push),
        .o_item (push_item)
    );

    dmarb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_item)
    );

    dmarb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head_item),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule

// ----- test/dmarb_monitor.sv -----
// ----------------------------------------------------------------------------
// dmarb_monitor
// Watches the request and response channels of the DMA register block, keeps
// its own copy of the register state, predicts each response and compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module dmarb_monitor
    import dmarb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    dmarb_req_if        i_req,
    dmarb_rsp_if        i_rsp,
    output int unsigned o_fail_count,
    output int unsigned o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CHCR_TO_DEVICE = 0;
    localparam int unsigned CHCR_STEP_BACK = 1;
    localparam int unsigned CHCR_START     = 24;
    localparam int unsigned CHCR_TRIGGER   = 28;
    localparam int unsigned DICR_BUS_ERR   = 15;
    localparam int unsigned DICR_ENABLE    = 23;
    localparam logic [2:0]  NO_CHANNEL     = 3'd7;
    localparam int unsigned MAX_PRINTS     = 40;

    logic [31:0] dpcr_q;
    logic [31:0] dicr_q;
    logic [23:0] madr_q;
    logic [31:0] bcr_q;
    logic [31:0] chcr_q;
    logic [6:0]  req_lines_q;

    t_result     expected_rsp[$];
    int unsigned mismatch_count = 0;
    int unsigned rsp_index = 0;

    assign o_fail_count = mismatch_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_PRINTS) begin
            $display("[%0t] response %0d: %s got %h expected %h", $realtime, rsp_index,
                     what, got, want);
        end
        mismatch_count++;
    endtask

    // master flag follows bus error, or enable with any masked flag raised
    function automatic void refresh_master();
        dicr_q[31] = dicr_q[DICR_BUS_ERR]
                   | (dicr_q[DICR_ENABLE] & (|(dicr_q[30:24] & dicr_q[22:16])));
    endfunction

    function automatic void try_slice_start(input logic [2:0] ch, inout t_result r);
        if (ch == LIVE_SLOT && dpcr_q[LIVE_EN_BIT] && chcr_q[CHCR_START]
                && req_lines_q[ch]) begin
            chcr_q[CHCR_TRIGGER] = 1'b0;
            if (chcr_q[10:9] == CHCR_MODE_SLICE && !chcr_q[CHCR_STEP_BACK]) begin
                r.xfer_valid       = 1'b1;
                r.xfer_to_device   = chcr_q[CHCR_TO_DEVICE];
                r.xfer_address     = madr_q;
                r.xfer_block_words = bcr_q[15:0];
                r.xfer_block_count = bcr_q[31:16];
                if (dicr_q[LIVE_MASK_BIT]) begin
                    dicr_q[LIVE_FLAG_BIT] = 1'b1;
                end
                refresh_master();
            end
        end
    endfunction

    function automatic t_result predict_access(input logic [1:0] kind, input logic [6:0] ofs,
                                               input logic [31:0] data, input logic [2:0] ch,
                                               input logic lvl);
        t_result     r;
        logic [31:0] kept_flags;
        r = '0;
        case (kind)
            REQ_READ: begin
                if (ofs == OFS_DPCR) begin
                    r.read_data = dpcr_q;
                end else if (ofs == OFS_DICR) begin
                    r.read_data = dicr_q;
                end else if (ofs[6:4] == LIVE_SLOT) begin
                    case (ofs[3:2])
                        REG_MADR: r.read_data = {8'h00, madr_q};
                        REG_BCR:  r.read_data = bcr_q;
                        REG_CHCR: r.read_data = chcr_q;
                        default:  r.read_data = '0;
                    endcase
                end
            end
            REQ_WRITE: begin
                if (ofs == OFS_DPCR) begin
                    dpcr_q = data;
                end else if (ofs == OFS_DICR) begin
                    // a set mask bit in the written value acknowledges its flag
                    kept_flags = dicr_q & DICR_FLAGS & ~{1'b0, data[22:16], 24'h0};
                    dicr_q     = (data & DICR_WR_MASK) | kept_flags;
                    refresh_master();
                end else if (ofs[6:4] == LIVE_SLOT) begin
                    case (ofs[3:2])
                        REG_MADR: madr_q = data[23:0] & MADR_MASK;
                        REG_BCR:  bcr_q  = data;
                        REG_CHCR: begin
                            chcr_q = data;
                            try_slice_start(LIVE_SLOT, r);
                        end
                        default: ;
                    endcase
                end
            end
            REQ_LINE: begin
                if (ch != NO_CHANNEL) begin
                    if (lvl) begin
                        req_lines_q[ch] = 1'b1;
                        try_slice_start(ch, r);
                    end else begin
                        req_lines_q[ch] = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        r.irq_master = dicr_q[31];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            dpcr_q      = DPCR_RESET;
            dicr_q      = '0;
            madr_q      = '0;
            bcr_q       = '0;
            chcr_q      = '0;
            req_lines_q = '0;
            expected_rsp.delete();
        end else begin
            // the response leaving now belongs to an earlier transaction
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{read_data:        i_rsp.read_data,
                        xfer_valid:       i_rsp.xfer_valid,
                        xfer_to_device:   i_rsp.xfer_to_device,
                        xfer_address:     i_rsp.xfer_address,
                        xfer_block_words: i_rsp.xfer_block_words,
                        xfer_block_count: i_rsp.xfer_block_count,
                        irq_master:       i_rsp.irq_master};
                if (expected_rsp.size() == 0) begin
                    report_mismatch("unexpected response, read_data", got.read_data, '0);
                end else begin
                    want = expected_rsp.pop_front();
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", got.read_data, want.read_data);
                    if (got.xfer_valid !== want.xfer_valid)
                        report_mismatch("xfer_valid", 32'(got.xfer_valid),
                                        32'(want.xfer_valid));
                    if (got.xfer_to_device !== want.xfer_to_device)
                        report_mismatch("xfer_to_device", 32'(got.xfer_to_device),
                                        32'(want.xfer_to_device));
                    if (got.xfer_address !== want.xfer_address)
                        report_mismatch("xfer_address", 32'(got.xfer_address),
                                        32'(want.xfer_address));
                    if (got.xfer_block_words !== want.xfer_block_words)
                        report_mismatch("xfer_block_words", 32'(got.xfer_block_words),
                                        32'(want.xfer_block_words));
                    if (got.xfer_block_count !== want.xfer_block_count)
                        report_mismatch("xfer_block_count", 32'(got.xfer_block_count),
                                        32'(want.xfer_block_count));
                    if (got.irq_master !== want.irq_master)
                        report_mismatch("irq_master", 32'(got.irq_master),
                                        32'(want.irq_master));
                end
                rsp_index++;
            end
            if (i_req.valid && i_req.ready) begin
                expected_rsp.push_back(predict_access(i_req.req_type, i_req.reg_offset,
                                                      i_req.write_data, i_req.request_channel,
                                                      i_req.request_level));
            end
        end
        o_outstanding <= expected_rsp.size();
    end

endmodule

// ----- test/dma_register_block_with_slice_trigger_tb.sv -----
// ----------------------------------------------------------------------------
// dma_register_block_with_slice_trigger_tb
// Drives bus reads, writes and request line changes into the DMA register
// block: a directed pass over the corner cases, then random traffic biased
// toward slice starts on the live channel, with bursty sender and stalling
// receiver. Checking is done by the monitor placed beside the block.
// ----------------------------------------------------------------------------
module dma_register_block_with_slice_trigger_tb
    import dmarb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  REQ_NONE       = 2'd3;
    localparam logic [6:0]  OFS_CH_MADR    = {LIVE_SLOT, REG_MADR, 2'b00};
    localparam logic [6:0]  OFS_CH_BCR     = {LIVE_SLOT, REG_BCR, 2'b00};
    localparam logic [6:0]  OFS_CH_CHCR    = {LIVE_SLOT, REG_CHCR, 2'b00};
    localparam logic [6:0]  OFS_CH_UNUSED  = {LIVE_SLOT, 2'd3, 2'b00};
    localparam logic [2:0]  NO_CHANNEL     = 3'd7;
    localparam int unsigned TOTAL_ITEMS    = 750;
    localparam int unsigned CYCLE_LIMIT    = 400000;

    typedef enum int unsigned {RX_OPEN, RX_SPARSE, RX_PERIODIC, RX_COIN} t_rx_mode;

    logic        i_clk;
    logic        i_rst_n;
    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned cycle_count = 0;
    int unsigned counted_items = 0;
    int unsigned burst_left = 1;
    int unsigned stall_left = 0;
    t_rx_mode    rx_mode = RX_OPEN;

    dmarb_req_if req_ch();
    dmarb_rsp_if rsp_ch();

    dma_register_block_with_slice_trigger DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    dmarb_monitor u_monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: stall pattern switches after a random countdown
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            rx_mode    <= t_rx_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(16, 96);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (rx_mode)
            RX_OPEN:     rsp_ch.ready <= 1'b1;
            RX_SPARSE:   rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: rsp_ch.ready <= ((stall_left % 5) >= 2);
            default:     rsp_ch.ready <= 1'($urandom_range(0, 1));
        endcase
    end

    // one transaction, then the sender's burst and gap pacing
    task automatic issue(input logic [1:0] kind, input logic [6:0] ofs, input logic [31:0] data,
                         input logic [2:0] ch, input logic lvl);
        int unsigned gap;
        req_ch.valid           <= 1'b1;
        req_ch.req_type        <= kind;
        req_ch.reg_offset      <= ofs;
        req_ch.write_data      <= data;
        req_ch.request_channel <= ch;
        req_ch.request_level   <= lvl;
        do @(posedge i_clk); while (!req_ch.ready);
        if (!(kind == REQ_NONE || (kind == REQ_LINE && ch == NO_CHANNEL))) begin
            counted_items++;
        end
        burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
            gap        = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 14)
                                                     : $urandom_range(0, 3);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        logic [1:0]  kind;
        logic [6:0]  ofs;
        logic [31:0] data;
        logic [2:0]  ch;
        logic        lvl;
        int unsigned pick;

        i_rst_n                <= 1'b0;
        req_ch.valid           <= 1'b0;
        req_ch.req_type        <= REQ_READ;
        req_ch.reg_offset      <= '0;
        req_ch.write_data      <= '0;
        req_ch.request_channel <= '0;
        req_ch.request_level   <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corner cases
        issue(REQ_READ,  OFS_DPCR,       '0, 3'd0, 1'b0);
        issue(REQ_READ,  OFS_CH_UNUSED,  '0, 3'd0, 1'b0);
        issue(REQ_WRITE, OFS_CH_MADR,    32'hffff_ffff, 3'd0, 1'b0);
        issue(REQ_READ,  OFS_CH_MADR | 7'h3, '0, 3'd0, 1'b0);
        issue(REQ_WRITE, OFS_CH_BCR,     32'hffff_ffff, 3'd0, 1'b0);
        issue(REQ_WRITE, OFS_DICR,       32'hffff_ffff, 3'd0, 1'b0);
        issue(REQ_READ,  OFS_DICR,       '0, 3'd0, 1'b0);
        issue(REQ_WRITE, OFS_DICR,       32'h0090_007f, 3'd0, 1'b0);
        issue(REQ_WRITE, OFS_DPCR,       DPCR_RESET | (32'h1 << LIVE_EN_BIT), 3'd0, 1'b0);
        issue(REQ_LINE,  OFS_DPCR,       '0, LIVE_SLOT, 1'b1);
        issue(REQ_WRITE, OFS_CH_CHCR,    32'h1100_0201, 3'd0, 1'b0);
        issue(REQ_READ,  OFS_CH_CHCR,    '0, 3'd0, 1'b0);
        issue(REQ_LINE,  '0,             '0, LIVE_SLOT, 1'b1);
        issue(REQ_WRITE, OFS_DICR,       32'h0010_0000, 3'd0, 1'b0);
        issue(REQ_WRITE, OFS_CH_BCR,     32'h0000_0000, 3'd0, 1'b0);
        issue(REQ_WRITE, OFS_CH_CHCR,    32'h0100_0000, 3'd0, 1'b0);
        issue(REQ_WRITE, OFS_CH_CHCR,    32'h0100_0400, 3'd0, 1'b0);
        issue(REQ_WRITE, OFS_CH_CHCR,    32'h0100_0600, 3'd0, 1'b0);
        issue(REQ_WRITE, OFS_CH_CHCR,    32'h0100_0203, 3'd0, 1'b0);
        issue(REQ_LINE,  '0,             '0, NO_CHANNEL, 1'b1);
        issue(REQ_LINE,  '0,             '0, 3'd2, 1'b1);
        issue(REQ_NONE,  7'h7f,          32'hffff_ffff, NO_CHANNEL, 1'b1);
        issue(REQ_WRITE, OFS_DPCR | 7'h1, '0, 3'd0, 1'b0);
        issue(REQ_WRITE, 7'h78,          32'hffff_ffff, 3'd0, 1'b0);
        issue(REQ_LINE,  '0,             '0, LIVE_SLOT, 1'b0);
        issue(REQ_WRITE, OFS_CH_CHCR,    32'h0100_0200, 3'd0, 1'b0);

        // random traffic, biased toward sequences that lead to slice starts
        while (counted_items < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 99);
            kind = REQ_WRITE;
            ofs  = 7'($urandom);
            data = $urandom;
            ch   = 3'($urandom);
            lvl  = 1'($urandom);
            if (pick < 15) begin
                kind = REQ_READ;
                case ($urandom_range(0, 3))
                    0:       ofs = OFS_DPCR;
                    1:       ofs = OFS_DICR;
                    2:       ofs = {LIVE_SLOT, 4'($urandom)};
                    default: ;
                endcase
            end else if (pick < 27) begin
                ofs = OFS_CH_CHCR;
                if ($urandom_range(0, 3) != 0) data[24] = 1'b1;
                if ($urandom_range(0, 3) != 0) data[10:9] = CHCR_MODE_SLICE;
                if ($urandom_range(0, 2) != 0) data[1] = 1'b0;
            end else if (pick < 35) begin
                ofs = ($urandom_range(0, 1) != 0) ? OFS_CH_MADR : OFS_CH_BCR;
            end else if (pick < 42) begin
                ofs = OFS_DICR;
                data[15] = ($urandom_range(0, 7) == 0);
                if ($urandom_range(0, 3) != 0) data[23] = 1'b1;
            end else if (pick < 47) begin
                ofs = OFS_DPCR;
                if ($urandom_range(0, 3) != 0) data[LIVE_EN_BIT] = 1'b1;
            end else if (pick < 77) begin
                kind = REQ_LINE;
                if ($urandom_range(0, 9) < 7) ch = LIVE_SLOT;
                if ($urandom_range(0, 3) != 0) lvl = 1'b1;
            end else if (pick < 88) begin
                kind = 2'($urandom);
            end else begin
                kind = REQ_READ;
                ofs  = OFS_DICR;
            end
            issue(kind, ofs, data, ch, lvl);
        end

        req_ch.valid <= 1'b0;
        // the pending count is a registered copy of the monitor's queue size, so it lags
        repeat (2) @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
